/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/flbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flbs_pkg
// Shared types, color codes and constants of the fault LED blink sequencer.
// ----------------------------------------------------------------------------
package flbs_pkg;

	// Field widths
	localparam int PLEN_W  = 16;
	localparam int TICK_W  = 16;
	localparam int ACC_W   = 18;
	localparam int COLOR_W = 3;

	localparam logic [PLEN_W-1:0] PLEN_RESET          = 16'd500;
	localparam logic [7:0]        VISION_VALID_HEADER = 8'hA5;

	// LED color codes
	localparam logic [COLOR_W-1:0] COLOR_OFF   = 3'd0;
	localparam logic [COLOR_W-1:0] COLOR_RED   = 3'd1;
	localparam logic [COLOR_W-1:0] COLOR_BLUE  = 3'd2;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 3'd3;
	localparam logic [COLOR_W-1:0] COLOR_GREEN = 3'd4;

	// Top-level sequencer states
	typedef enum logic [1:0] {
		T_IDLE,
		T_START,
		T_WAIT,
		T_EMIT
	} top_state_t;

	// Modulo unit sequencer states
	typedef enum logic [1:0] {
		M_IDLE,
		M_DIV,
		M_PHASE,
		M_DONE
	} mod_state_t;

	// Request into the modulo unit
	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  sum;
		logic [ACC_W-1:0]  period;
		logic [PLEN_W-1:0] plen;
		logic [1:0]        max_phase;
	} mod_req_t;

	// Answer from the modulo unit
	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] acc;
		logic [1:0]       phase;
	} mod_rsp_t;

endpackage

/* hw/rtl/flbs_tick_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flbs_tick_if
// Valid/ready channel carrying one monitor tick word.
// ----------------------------------------------------------------------------
interface flbs_tick_if;
	logic        valid;
	logic        ready;
	logic        bus_fault;
	logic [7:0]  vision_header;
	logic [31:0] vision_distance_bits;
	logic [7:0]  vision_checksum;
	logic        gantry_up;
	logic        ref_heartbeat;
	logic [15:0] elapsed_ticks;

	modport source (
		output valid, bus_fault, vision_header, vision_distance_bits,
		       vision_checksum, gantry_up, ref_heartbeat, elapsed_ticks,
		input  ready
	);
	modport sink (
		input  valid, bus_fault, vision_header, vision_distance_bits,
		       vision_checksum, gantry_up, ref_heartbeat, elapsed_ticks,
		output ready
	);
endinterface

/* hw/rtl/flbs_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flbs_result_if
// Valid/ready channel carrying one LED result word.
// ----------------------------------------------------------------------------
interface flbs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] led_color;
	logic       led_write;
	logic [3:0] fault_pattern;
	logic [1:0] phase_index;
	logic       vision_fault;

	modport source (
		output valid, led_color, led_write, fault_pattern, phase_index, vision_fault,
		input  ready
	);
	modport sink (
		input  valid, led_color, led_write, fault_pattern, phase_index, vision_fault,
		output ready
	);
endinterface

/* hw/rtl/fault_led_blink_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fault_led_blink_sequencer_core
// Monitor-tick driven fault LED sequencer with per-length phase accumulators.
// ----------------------------------------------------------------------------
// One tick word yields one result word. A tick with at least one color in its
// list goes in order through a start of flbs_mod_unit, 18 restoring-division
// steps through its shared compare/subtract unit, one to three phase steps on
// the same unit, the hand-back of the answer and the load of the output
// register; a tick whose list is empty goes straight to the output register.
// The input is not ready while a tick is in work and is ready again the cycle
// after the result is loaded, so a new tick is taken only once the last one is
// through. A finished result waits in the output register and the next tick is
// accepted meanwhile; its result is held until that register is free. The
// user must write phase_length through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. A value of zero acts as one.
module fault_led_blink_sequencer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	flbs_tick_if.sink                    tick,
	flbs_result_if.source                result,
	input  logic                         cfg_we,
	input  logic [flbs_pkg::PLEN_W-1:0]  cfg_wdata
);

	localparam int ACC_W   = flbs_pkg::ACC_W;
	localparam int PLEN_W  = flbs_pkg::PLEN_W;
	localparam int COLOR_W = flbs_pkg::COLOR_W;

	flbs_pkg::top_state_t state_q, state_d;

	logic [PLEN_W-1:0]  phase_length_q;
	logic [ACC_W-1:0]   acc_q [3];
	logic [COLOR_W-1:0] shown_color_q;

	logic [COLOR_W-1:0] list_q [3];
	logic [1:0]         count_q;
	logic [3:0]         pattern_q;
	logic               vision_q;
	logic [1:0]         phase_q;
	logic [ACC_W-1:0]   sum_q;
	logic [ACC_W-1:0]   period_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [1:0]         max_phase_q;

	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_write_q;
	logic [3:0]         out_pattern_q;
	logic [1:0]         out_phase_q;
	logic               out_vision_q;

	flbs_pkg::mod_req_t mod_req;
	flbs_pkg::mod_rsp_t mod_rsp;

	logic tick_fire, out_free, emit_fire;

	// Decode the tick word
	logic               vision_c, gantry_err_c;
	logic [COLOR_W-1:0] list_c [3];
	logic [1:0]         count_c;
	logic [3:0]         pattern_c;
	logic [1:0]         slot_c;
	logic [PLEN_W-1:0]  plen_c;
	logic [ACC_W-1:0]   period_c;
	logic [ACC_W-1:0]   sum_c;

	always_comb begin
		vision_c = (tick.vision_header != flbs_pkg::VISION_VALID_HEADER) ||
		           (tick.vision_distance_bits[30:0] == 31'd0) ||
		           (tick.vision_checksum == 8'd0);
		gantry_err_c = ~tick.gantry_up;
		list_c[0] = flbs_pkg::COLOR_OFF;
		list_c[1] = flbs_pkg::COLOR_OFF;
		list_c[2] = flbs_pkg::COLOR_OFF;
		count_c   = 2'd0;
		if (tick.bus_fault) begin
			list_c[count_c] = flbs_pkg::COLOR_RED;
			count_c = count_c + 2'd1;
		end
		if (vision_c) begin
			list_c[count_c] = flbs_pkg::COLOR_BLUE;
			count_c = count_c + 2'd1;
		end
		if (gantry_err_c) begin
			list_c[count_c] = flbs_pkg::COLOR_WHITE;
			count_c = count_c + 2'd1;
		end
		if (count_c == 2'd0 && tick.ref_heartbeat) begin
			list_c[0] = flbs_pkg::COLOR_GREEN;
			count_c = 2'd1;
		end
		pattern_c = {(count_c == 2'd1 && list_c[0] == flbs_pkg::COLOR_GREEN),
		             gantry_err_c, vision_c, tick.bus_fault};
		slot_c = count_c - 2'd1;
		plen_c = (phase_length_q == '0) ? PLEN_W'(1) : phase_length_q;
		// period is two phases for a single color, otherwise one per color
		period_c = {1'b0, plen_c, 1'b0} +
		           ((count_c == 2'd3) ? {2'b00, plen_c} : '0);
		sum_c = acc_q[slot_c] + {{(ACC_W-PLEN_W){1'b0}}, tick.elapsed_ticks};
	end

	// Pick the color from the phase
	logic [COLOR_W-1:0] color_c;
	always_comb begin
		color_c = flbs_pkg::COLOR_OFF;
		case (count_q)
			2'd0: color_c = flbs_pkg::COLOR_OFF;
			2'd1: color_c = (phase_q == 2'd1) ? list_q[0] : flbs_pkg::COLOR_OFF;
			default: begin
				case (phase_q)
					2'd0:    color_c = list_q[0];
					2'd1:    color_c = list_q[1];
					default: color_c = list_q[2];
				endcase
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			flbs_pkg::T_IDLE:
				if (tick_fire) state_d = (count_c == 2'd0) ? flbs_pkg::T_EMIT : flbs_pkg::T_START;
			flbs_pkg::T_START: state_d = flbs_pkg::T_WAIT;
			flbs_pkg::T_WAIT:  if (mod_rsp.done) state_d = flbs_pkg::T_EMIT;
			flbs_pkg::T_EMIT:  if (out_free) state_d = flbs_pkg::T_IDLE;
			default:           state_d = flbs_pkg::T_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		tick.ready        = (state_q == flbs_pkg::T_IDLE);
		tick_fire         = tick.valid && (state_q == flbs_pkg::T_IDLE);
		out_free          = ~out_valid_q | result.ready;
		emit_fire         = (state_q == flbs_pkg::T_EMIT) && out_free;
		mod_req.start     = (state_q == flbs_pkg::T_START);
		mod_req.sum       = sum_q;
		mod_req.period    = period_q;
		mod_req.plen      = plen_q;
		mod_req.max_phase = max_phase_q;
	end

	flbs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flbs_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, accumulators and displayed color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= flbs_pkg::PLEN_RESET;
			acc_q[0]       <= '0;
			acc_q[1]       <= '0;
			acc_q[2]       <= '0;
			shown_color_q  <= flbs_pkg::COLOR_WHITE;
		end else begin
			if (cfg_we) phase_length_q <= cfg_wdata;
			if (state_q == flbs_pkg::T_WAIT && mod_rsp.done)
				acc_q[count_q - 2'd1] <= mod_rsp.acc;
			if (emit_fire) shown_color_q <= color_c;
		end
	end

	// Hold the decoded tick and the phase
	always_ff @(posedge clk) begin
		if (tick_fire) begin
			list_q      <= list_c;
			count_q     <= count_c;
			pattern_q   <= pattern_c;
			vision_q    <= vision_c;
			phase_q     <= 2'd0;
			sum_q       <= sum_c;
			period_q    <= period_c;
			plen_q      <= plen_c;
			max_phase_q <= (count_c == 2'd1) ? 2'd1 : count_c - 2'd1;
		end else if (state_q == flbs_pkg::T_WAIT && mod_rsp.done) begin
			phase_q <= mod_rsp.phase;
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_color_q   <= color_c;
			out_write_q   <= (color_c != shown_color_q);
			out_pattern_q <= pattern_q;
			out_phase_q   <= phase_q;
			out_vision_q  <= vision_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.led_color     = out_color_q;
	assign result.led_write     = out_write_q;
	assign result.fault_pattern = out_pattern_q;
	assign result.phase_index   = out_phase_q;
	assign result.vision_fault  = out_vision_q;

endmodule

/* hw/rtl/flbs_mod_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flbs_mod_unit
// Iterative modulo and phase unit built around one shared compare/subtract.
// Restoring division gives sum mod period, then repeated subtraction of the
// phase length gives the phase index.
// ----------------------------------------------------------------------------
module flbs_mod_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  flbs_pkg::mod_req_t req,
	output flbs_pkg::mod_rsp_t rsp
);

	localparam int ACC_W = flbs_pkg::ACC_W;
	localparam int CNT_W = $clog2(ACC_W);

	flbs_pkg::mod_state_t state_q, state_d;

	logic [ACC_W:0]               rem_q;
	logic [ACC_W-1:0]             dvd_q;
	logic [ACC_W-1:0]             per_q;
	logic [flbs_pkg::PLEN_W-1:0]  plen_q;
	logic [1:0]                   max_phase_q;
	logic [1:0]                   phase_q;
	logic [ACC_W-1:0]             acc_q;
	logic [CNT_W-1:0]             cnt_q;

	// Shared compare/subtract
	logic [ACC_W:0]   op_a, op_b;
	logic [ACC_W+1:0] diff_c;
	logic             ge_c;
	logic [ACC_W:0]   rem_next;

	assign diff_c   = {1'b0, op_a} - {1'b0, op_b};
	assign ge_c     = ~diff_c[ACC_W+1];
	assign rem_next = ge_c ? diff_c[ACC_W:0] : op_a;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			flbs_pkg::M_IDLE:  if (req.start) state_d = flbs_pkg::M_DIV;
			flbs_pkg::M_DIV:   if (cnt_q == '0) state_d = flbs_pkg::M_PHASE;
			flbs_pkg::M_PHASE: if (!ge_c || phase_q == max_phase_q) state_d = flbs_pkg::M_DONE;
			flbs_pkg::M_DONE:  state_d = flbs_pkg::M_IDLE;
			default:           state_d = flbs_pkg::M_IDLE;
		endcase
	end

	// Operand select and answer
	always_comb begin
		op_a = rem_q;
		op_b = {1'b0, per_q};
		unique case (state_q)
			flbs_pkg::M_DIV: begin
				op_a = {rem_q[ACC_W-1:0], dvd_q[ACC_W-1]};
				op_b = {1'b0, per_q};
			end
			flbs_pkg::M_PHASE: begin
				op_a = rem_q;
				op_b = {{(ACC_W+1-flbs_pkg::PLEN_W){1'b0}}, plen_q};
			end
			default: begin
				op_a = rem_q;
				op_b = {1'b0, per_q};
			end
		endcase
		rsp.done  = (state_q == flbs_pkg::M_DONE);
		rsp.acc   = acc_q;
		rsp.phase = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flbs_pkg::M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			flbs_pkg::M_IDLE: begin
				if (req.start) begin
					rem_q       <= '0;
					dvd_q       <= req.sum;
					per_q       <= req.period;
					plen_q      <= req.plen;
					max_phase_q <= req.max_phase;
					phase_q     <= '0;
					cnt_q       <= CNT_W'(ACC_W - 1);
				end
			end
			flbs_pkg::M_DIV: begin
				// shift in one dividend bit, subtract when it fits
				rem_q <= rem_next;
				dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) acc_q <= rem_next[ACC_W-1:0];
			end
			flbs_pkg::M_PHASE: begin
				// step the phase while the remainder still covers a full phase
				if (ge_c && phase_q != max_phase_q) begin
					rem_q   <= diff_c[ACC_W:0];
					phase_q <= phase_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/flbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flbs_checker
// Port-level checks of the fault LED blink sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] led_color,
	input logic       led_write,
	input logic [3:0] fault_pattern,
	input logic [1:0] phase_index,
	input logic       vision_fault
);

	// A stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({led_color, led_write, fault_pattern, phase_index, vision_fault}))

	// A tick in work blocks the next one
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// An off LED always sits in phase zero
	`ASSERT_IMPL(a_off_phase_zero, clk, arst_n, out_valid && led_color == flbs_pkg::COLOR_OFF, phase_index == 2'd0)

	// Healthy green excludes every fault and every other color
	`ASSERT_IMPL(a_green_healthy, clk, arst_n, out_valid && fault_pattern[3], fault_pattern[2:0] == 3'd0 && !vision_fault && (led_color == flbs_pkg::COLOR_OFF || led_color == flbs_pkg::COLOR_GREEN))

endmodule

bind fault_led_blink_sequencer_core flbs_checker u_flbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (tick.valid),
	.in_ready      (tick.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.led_color     (result.led_color),
	.led_write     (result.led_write),
	.fault_pattern (result.fault_pattern),
	.phase_index   (result.phase_index),
	.vision_fault  (result.vision_fault)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fault LED blink sequencer core. A directed table
// covers field extremes, every color list and the blink/cycle phases, then
// random monitor ticks run under several phase lengths (zero and full scale
// among them). A local predictor tracks the phase accumulators, the shown
// color and the phase length; every result word is compared field by field
// in order. The sender works in bursts and the receiver stalls on its own
// pattern, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PLEN_W  = flbs_pkg::PLEN_W;
	localparam int TICK_W  = flbs_pkg::TICK_W;
	localparam int COLOR_W = flbs_pkg::COLOR_W;

	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 216;
	localparam int DIR_ROWS        = 22;
	localparam int HOLD_CYCLES     = 600;
	localparam int HOLD_AT_WORD    = 350;
	localparam int TAIL_CYCLES     = 40;

	// Fault pattern bits
	localparam logic [3:0] PAT_NONE   = 4'b0000;
	localparam logic [3:0] PAT_BUS    = 4'b0001;
	localparam logic [3:0] PAT_VISION = 4'b0010;
	localparam logic [3:0] PAT_GANTRY = 4'b0100;
	localparam logic [3:0] PAT_GREEN  = 4'b1000;

	localparam logic [31:0] DIST_ONE   = 32'h3F80_0000;
	localparam logic [31:0] DIST_NAN   = 32'h7FC0_0000;
	localparam logic [31:0] DIST_NEG_0 = 32'h8000_0000;

	typedef struct packed {
		logic              bus_fault;
		logic [7:0]        vision_header;
		logic [31:0]       vision_distance_bits;
		logic [7:0]        vision_checksum;
		logic              gantry_up;
		logic              ref_heartbeat;
		logic [TICK_W-1:0] elapsed_ticks;
	} tick_word_t;

	typedef struct packed {
		logic [COLOR_W-1:0] led_color;
		logic               led_write;
		logic [3:0]         fault_pattern;
		logic [1:0]         phase_index;
		logic               vision_fault;
	} led_word_t;

	typedef struct packed {
		tick_word_t tick;
		logic       typed;
		led_word_t  want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [PLEN_W-1:0] cfg_wdata;

	flbs_tick_if   tick_ch ();
	flbs_result_if led_ch ();

	fault_led_blink_sequencer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (led_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state
	int unsigned        phase_acc [3];
	logic [COLOR_W-1:0] shown_color;
	logic [PLEN_W-1:0]  phase_len;

	led_word_t   pending_leds [$];
	led_word_t   got_led;
	led_word_t   want_led;
	int          fail_count;
	int          words_out;
	int          burst_left;

	// Directed table: typed expectations where they are plain, else predicted
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{'{1'b0, 8'hA5, DIST_ONE, 8'h5A, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_OFF, 1'b1, PAT_GREEN, 2'd0, 1'b0}},
		'{'{1'b0, 8'hA5, DIST_ONE, 8'h5A, 1'b1, 1'b1, 16'd500}, 1'b1,
			'{flbs_pkg::COLOR_GREEN, 1'b1, PAT_GREEN, 2'd1, 1'b0}},
		'{'{1'b0, 8'hA5, DIST_ONE, 8'h5A, 1'b1, 1'b0, 16'd65535}, 1'b1,
			'{flbs_pkg::COLOR_OFF, 1'b1, PAT_NONE, 2'd0, 1'b0}},
		'{'{1'b1, 8'hA5, DIST_ONE, 8'h5A, 1'b1, 1'b0, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_RED, 1'b1, PAT_BUS, 2'd1, 1'b0}},
		'{'{1'b0, 8'h00, DIST_ONE, 8'h5A, 1'b1, 1'b1, 16'd499}, 1'b1,
			'{flbs_pkg::COLOR_BLUE, 1'b1, PAT_VISION, 2'd1, 1'b1}},
		'{'{1'b0, 8'hA5, 32'h0, 8'h5A, 1'b1, 1'b1, 16'd1}, 1'b1,
			'{flbs_pkg::COLOR_OFF, 1'b1, PAT_VISION, 2'd0, 1'b1}},
		'{'{1'b0, 8'hA5, DIST_NEG_0, 8'h5A, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_OFF, 1'b0, PAT_VISION, 2'd0, 1'b1}},
		'{'{1'b0, 8'hA5, DIST_ONE, 8'h00, 1'b1, 1'b1, 16'd65535}, 1'b1,
			'{flbs_pkg::COLOR_BLUE, 1'b1, PAT_VISION, 2'd1, 1'b1}},
		'{'{1'b0, 8'hA5, DIST_NAN, 8'h5A, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_GREEN, 1'b1, PAT_GREEN, 2'd1, 1'b0}},
		'{'{1'b0, 8'hA5, DIST_ONE, 8'h5A, 1'b0, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_WHITE, 1'b1, PAT_GANTRY, 2'd1, 1'b0}},
		'{'{1'b1, 8'hA5, DIST_ONE, 8'h5A, 1'b0, 1'b0, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_RED, 1'b1, PAT_BUS | PAT_GANTRY, 2'd0, 1'b0}},
		'{'{1'b1, 8'hA5, DIST_ONE, 8'h5A, 1'b0, 1'b0, 16'd500}, 1'b1,
			'{flbs_pkg::COLOR_WHITE, 1'b1, PAT_BUS | PAT_GANTRY, 2'd1, 1'b0}},
		'{'{1'b1, 8'hFF, 32'h0, 8'h00, 1'b0, 1'b1, 16'd1000}, 1'b1,
			'{flbs_pkg::COLOR_WHITE, 1'b0, PAT_BUS | PAT_VISION | PAT_GANTRY, 2'd2, 1'b1}},
		'{'{1'b1, 8'hFF, 32'h0, 8'h00, 1'b0, 1'b1, 16'd500}, 1'b1,
			'{flbs_pkg::COLOR_RED, 1'b1, PAT_BUS | PAT_VISION | PAT_GANTRY, 2'd0, 1'b1}},
		'{'{1'b1, 8'hA5, DIST_ONE, 8'h00, 1'b1, 1'b0, 16'd65535}, 1'b1,
			'{flbs_pkg::COLOR_RED, 1'b0, PAT_BUS | PAT_VISION, 2'd0, 1'b1}},
		'{'{1'b0, 8'h5A, DIST_ONE, 8'h5A, 1'b0, 1'b1, 16'd999}, 1'b1,
			'{flbs_pkg::COLOR_BLUE, 1'b1, PAT_VISION | PAT_GANTRY, 2'd0, 1'b1}},
		'{'{1'b0, 8'hA5, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_GREEN, 1'b1, PAT_GREEN, 2'd1, 1'b0}},
		'{'{1'b0, 8'hA4, 32'h0000_0001, 8'h01, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{flbs_pkg::COLOR_BLUE, 1'b1, PAT_VISION, 2'd1, 1'b1}},
		'{'{1'b0, 8'hA5, 32'h0000_0001, 8'h01, 1'b1, 1'b1, 16'd465}, 1'b1,
			'{flbs_pkg::COLOR_OFF, 1'b1, PAT_GREEN, 2'd0, 1'b0}},
		'{'{1'b1, 8'hA5, 32'h4120_0000, 8'h33, 1'b1, 1'b1, 16'd123}, 1'b0, '0},
		'{'{1'b0, 8'h7E, 32'hC2F6_E979, 8'hC3, 1'b0, 1'b0, 16'd40000}, 1'b0, '0},
		'{'{1'b1, 8'h00, 32'h0000_8000, 8'hFF, 1'b0, 1'b1, 16'd777}, 1'b0, '0}
	};

	// Work out the LED word for one accepted tick and advance the state
	function automatic led_word_t predict_led(input tick_word_t w);
		logic               vis;
		logic               gantry_err;
		logic               green_only;
		logic [COLOR_W-1:0] colors [0:2];
		int unsigned        n;
		int unsigned        span;
		int unsigned        plen_eff;
		int unsigned        acc;
		int unsigned        ph;
		led_word_t          r;
		vis = (w.vision_header != flbs_pkg::VISION_VALID_HEADER) ||
			(w.vision_distance_bits[30:0] == '0) || (w.vision_checksum == '0);
		gantry_err = !w.gantry_up;
		green_only = 1'b0;
		colors = '{flbs_pkg::COLOR_OFF, flbs_pkg::COLOR_OFF, flbs_pkg::COLOR_OFF};
		n = 0;
		if (w.bus_fault) begin
			colors[2'(n)] = flbs_pkg::COLOR_RED;
			n++;
		end
		if (vis) begin
			colors[2'(n)] = flbs_pkg::COLOR_BLUE;
			n++;
		end
		if (gantry_err) begin
			colors[2'(n)] = flbs_pkg::COLOR_WHITE;
			n++;
		end
		if (n == 0 && w.ref_heartbeat) begin
			colors[0] = flbs_pkg::COLOR_GREEN;
			n = 1;
			green_only = 1'b1;
		end
		r.fault_pattern = (w.bus_fault ? PAT_BUS : PAT_NONE) | (vis ? PAT_VISION : PAT_NONE) |
			(gantry_err ? PAT_GANTRY : PAT_NONE) | (green_only ? PAT_GREEN : PAT_NONE);
		plen_eff = (phase_len == '0) ? 1 : phase_len;
		r.led_color = flbs_pkg::COLOR_OFF;
		ph = 0;
		// Advance the accumulator that serves this list length
		if (n != 0) begin
			span = (n == 1) ? 2 : n;
			acc = (phase_acc[2'(n - 1)] + w.elapsed_ticks) % (plen_eff * span);
			phase_acc[2'(n - 1)] = acc;
			ph = acc / plen_eff;
			if (ph >= span)
				ph = span - 1;
			if (n > 1)
				r.led_color = colors[2'(ph)];
			else if (ph == 1)
				r.led_color = colors[0];
		end
		r.led_write = (r.led_color != shown_color);
		if (r.led_write)
			shown_color = r.led_color;
		r.phase_index = ph[1:0];
		r.vision_fault = vis;
		return r;
	endfunction

	// Random tick: mostly plausible vision data, with every fault mode mixed in
	function automatic tick_word_t random_tick();
		tick_word_t  w;
		int unsigned span;
		int unsigned top;
		w.bus_fault = 1'($urandom_range(0, 1));
		w.vision_header = flbs_pkg::VISION_VALID_HEADER;
		w.vision_distance_bits = $urandom;
		if (w.vision_distance_bits[30:0] == '0)
			w.vision_distance_bits[0] = 1'b1;
		w.vision_checksum = 8'($urandom_range(1, 255));
		case ($urandom_range(0, 7))
			0: w.vision_header = 8'($urandom);
			1: w.vision_distance_bits = {1'($urandom_range(0, 1)), 31'd0};
			2: w.vision_checksum = '0;
			3: begin
				w.vision_header = 8'($urandom);
				w.vision_checksum = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
			end
			default: ;
		endcase
		w.gantry_up = ($urandom_range(0, 3) != 0);
		w.ref_heartbeat = ($urandom_range(0, 3) != 0);
		span = (phase_len == '0) ? 1 : phase_len;
		top = (3 * span > 65535) ? 65535 : 3 * span;
		case ($urandom_range(0, 9))
			0: w.elapsed_ticks = '0;
			1: w.elapsed_ticks = '1;
			2, 3: w.elapsed_ticks = TICK_W'($urandom);
			4, 5: w.elapsed_ticks = span[TICK_W-1:0];
			default: w.elapsed_ticks = TICK_W'($urandom_range(0, top));
		endcase
		return w;
	endfunction

	// Offer one tick word in a burst; hold it until accepted, then predict
	task automatic send_tick(input tick_word_t w, input logic typed, input led_word_t want);
		int gap;
		led_word_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				@(negedge clk);
				tick_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		tick_ch.valid                <= 1'b1;
		tick_ch.bus_fault            <= w.bus_fault;
		tick_ch.vision_header        <= w.vision_header;
		tick_ch.vision_distance_bits <= w.vision_distance_bits;
		tick_ch.vision_checksum      <= w.vision_checksum;
		tick_ch.gantry_up            <= w.gantry_up;
		tick_ch.ref_heartbeat        <= w.ref_heartbeat;
		tick_ch.elapsed_ticks        <= w.elapsed_ticks;
		do @(posedge clk); while (!tick_ch.ready);
		r = predict_led(w);
		pending_leds.push_back(typed ? want : r);
	endtask

	// Drop valid and wait until every result word has come back
	task automatic drain_leds();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (pending_leds.size() != 0) @(posedge clk);
	endtask

	task automatic write_phase_length(input logic [PLEN_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		phase_len = v;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: switch between always-ready, coin-flip and mostly-stalled modes
	initial begin
		int mode;
		int mode_left;
		bit held_off;
		mode = 0;
		mode_left = 0;
		held_off = 1'b0;
		led_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && words_out >= HOLD_AT_WORD) begin
				held_off = 1'b1;
				led_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (mode)
				0: led_ch.ready <= 1'b1;
				1: led_ch.ready <= 1'($urandom_range(0, 1));
				default: led_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && led_ch.valid && led_ch.ready) begin
			words_out++;
			got_led = '{led_ch.led_color, led_ch.led_write, led_ch.fault_pattern,
				led_ch.phase_index, led_ch.vision_fault};
			if (pending_leds.size() == 0) begin
				$error("result word with no prediction pending");
				fail_count++;
			end else begin
				want_led = pending_leds.pop_front();
				check_field("led_color", int'(want_led.led_color),
					int'(got_led.led_color));
				check_field("led_write", int'(want_led.led_write),
					int'(got_led.led_write));
				check_field("fault_pattern", int'(want_led.fault_pattern),
					int'(got_led.fault_pattern));
				check_field("phase_index", int'(want_led.phase_index),
					int'(got_led.phase_index));
				check_field("vision_fault", int'(want_led.vision_fault),
					int'(got_led.vision_fault));
			end
		end
	end

	// Main sequence: reset, directed table, then random phases
	initial begin
		int unsigned plen_plan [RANDOM_PHASES];
		int p;
		int k;
		fail_count = 0;
		words_out = 0;
		burst_left = 0;
		phase_acc = '{0, 0, 0};
		shown_color = flbs_pkg::COLOR_WHITE;
		phase_len = flbs_pkg::PLEN_RESET;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.bus_fault = 1'b0;
		tick_ch.vision_header = '0;
		tick_ch.vision_distance_bits = '0;
		tick_ch.vision_checksum = '0;
		tick_ch.gantry_up = 1'b0;
		tick_ch.ref_heartbeat = 1'b0;
		tick_ch.elapsed_ticks = '0;
		plen_plan = '{1, 0, 65535, 2, 17, 500, 0, 0};
		plen_plan[6] = $urandom_range(1, 300);
		plen_plan[7] = $urandom_range(1, 65535);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIR_ROWS; k++)
			send_tick(dir_rows[5'(k)].tick, dir_rows[5'(k)].typed, dir_rows[5'(k)].want);
		drain_leds();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_phase_length(plen_plan[3'(p)][PLEN_W-1:0]);
			for (k = 0; k < WORDS_PER_PHASE; k++)
				send_tick(random_tick(), 1'b0, '0);
			drain_leds();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
